[hdl/sst_pkg.sv]
// shared types, codes and constants for the stream slot table
package sst_pkg;

  typedef enum logic [1:0] {
    CMD_OPEN      = 2'd0,
    CMD_DATA      = 2'd1,
    CMD_CLOSE     = 2'd2,
    CMD_CLOSE_ALL = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_IN_USE    = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_READ,
    S_CHECK,
    S_REPORT
  } state_t;

  localparam logic [7:0] OPEN_MIN_LEN  = 8'd8;
  localparam logic [7:0] DATA_MIN_LEN  = 8'd2;
  localparam logic [7:0] CLOSE_MIN_LEN = 8'd1;

  // packed attribute word kept beside the id: format, rate, device, type
  localparam int ATTR_W  = 40;
  localparam int ENTRY_W = ATTR_W + 8;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic early;
    logic scan_start;
    logic step;
    logic on_hit;
    logic on_miss;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic close_all;
    logic too_short;
    logic hit;
    logic last;
    logic out_free;
  } dp_stat_t;

  function automatic logic [7:0] min_len(cmd_t cmd);
    logic [7:0] n;
    unique case (cmd)
      CMD_OPEN:      n = OPEN_MIN_LEN;
      CMD_DATA:      n = DATA_MIN_LEN;
      CMD_CLOSE:     n = CLOSE_MIN_LEN;
      CMD_CLOSE_ALL: n = 8'd0;
    endcase
    return n;
  endfunction

endpackage

[hdl/stream_slot_table.sv]
// top level of the stream slot table
// Each command is one transfer in and gives one result transfer out. Close-all and
// commands with a short payload go from the evaluate state straight to the report
// state. Open, data and close scan the slots in index order, each slot in a ram read
// state and then a compare state, stopping at the first active match. Every result is
// loaded from the report state once the previous result has left the output register,
// so a previous result that stays stalled there holds the command back. The scan
// through the single-read entry ram sets how long a command takes. A new command is
// taken once the previous result is in the output register, even if that result
// is still stalled. Valid marks reset to cleared; no clearing pass is needed.
module stream_slot_table #(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_payload_len,
  input  logic [7:0]  in_stream_id,
  input  logic [7:0]  in_stream_type,
  input  logic [7:0]  in_device_id,
  input  logic [15:0] in_sample_rate,
  input  logic [7:0]  in_sample_format,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [2:0]  out_slot,
  output logic [3:0]  out_active_count
);

  sst_pkg::ctrl_cmd_t ctl;
  sst_pkg::dp_stat_t  stat;

  sst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  sst_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .stat             (stat),
    .in_cmd           (in_cmd),
    .in_payload_len   (in_payload_len),
    .in_stream_id     (in_stream_id),
    .in_stream_type   (in_stream_type),
    .in_device_id     (in_device_id),
    .in_sample_rate   (in_sample_rate),
    .in_sample_format (in_sample_format),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_active_count (out_active_count)
  );

endmodule

[hdl/sst_ram.sv]
// generic single write, single read ram with registered read data
module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/sst_datapath.sv]
// slot table datapath: command latch, valid marks, entry ram, scan index and result register
module sst_datapath #(
  parameter int SLOTS = 8,
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sst_pkg::ctrl_cmd_t  ctl,
  output sst_pkg::dp_stat_t   stat,
  input  logic [1:0]          in_cmd,
  input  logic [7:0]          in_payload_len,
  input  logic [7:0]          in_stream_id,
  input  logic [7:0]          in_stream_type,
  input  logic [7:0]          in_device_id,
  input  logic [15:0]         in_sample_rate,
  input  logic [7:0]          in_sample_format,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [2:0]          out_status,
  output logic [2:0]          out_slot,
  output logic [3:0]          out_active_count
);

  sst_pkg::cmd_t    cmd_r, cmd_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [7:0]       id_r, id_nxt;
  logic [sst_pkg::ATTR_W-1:0] attr_r, attr_nxt;

  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic             free_found_r, free_found_nxt;
  logic [IW-1:0]    free_idx_r, free_idx_nxt;

  sst_pkg::status_t res_status_r, res_status_nxt;
  logic [IW-1:0]    res_slot_r, res_slot_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [2:0]       out_status_r, out_status_nxt;
  logic [2:0]       out_slot_r, out_slot_nxt;
  logic [3:0]       out_count_r, out_count_nxt;

  logic                        ram_we;
  logic [sst_pkg::ENTRY_W-1:0] rd_word;
  logic                        hit;
  logic                        free_avail;
  logic [IW-1:0]               free_sel;
  logic [IW+2:0]               slot_ext;
  logic [CW+3:0]               count_ext;

  sst_ram #(
    .WIDTH (sst_pkg::ENTRY_W),
    .DEPTH (SLOTS)
  ) u_entries (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (free_sel),
    .wr_data ({attr_r, id_r}),
    .rd_addr (idx_r),
    .rd_data (rd_word)
  );

  assign hit        = valid_r[idx_r] && (rd_word[7:0] == id_r);
  assign free_avail = free_found_r || !valid_r[idx_r];
  assign free_sel   = free_found_r ? free_idx_r : idx_r;
  assign slot_ext   = (IW + 3)'(res_slot_r);
  assign count_ext  = (CW + 4)'(count_r);

  assign stat.close_all = (cmd_r == sst_pkg::CMD_CLOSE_ALL);
  assign stat.too_short = (len_r < sst_pkg::min_len(cmd_r));
  assign stat.hit       = hit;
  assign stat.last      = (idx_r == IW'(SLOTS - 1));
  assign stat.out_free  = !out_valid_r || !out_stall;

  always_comb begin
    cmd_nxt        = cmd_r;
    len_nxt        = len_r;
    id_nxt         = id_r;
    attr_nxt       = attr_r;
    valid_nxt      = valid_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;

    if (ctl.latch) begin
      cmd_nxt  = sst_pkg::cmd_t'(in_cmd);
      len_nxt  = in_payload_len;
      id_nxt   = in_stream_id;
      attr_nxt = {in_sample_format, in_sample_rate, in_device_id, in_stream_type};
    end

    if (ctl.early) begin
      res_slot_nxt = '0;
      if (cmd_r == sst_pkg::CMD_CLOSE_ALL) begin
        valid_nxt      = '0;
        count_nxt      = '0;
        res_status_nxt = sst_pkg::ST_OK;
      end else begin
        res_status_nxt = sst_pkg::ST_SHORT;
      end
    end

    if (ctl.scan_start) begin
      idx_nxt        = '0;
      free_found_nxt = 1'b0;
    end

    if (ctl.step) begin
      // remember the lowest free slot seen so far
      if (!valid_r[idx_r] && !free_found_r) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = idx_r;
      end
      idx_nxt = IW'(idx_r + 1'b1);
    end

    if (ctl.on_hit) begin
      if (cmd_r == sst_pkg::CMD_OPEN) begin
        res_status_nxt = sst_pkg::ST_IN_USE;
        res_slot_nxt   = '0;
      end else begin
        if (cmd_r == sst_pkg::CMD_CLOSE) begin
          valid_nxt[idx_r] = 1'b0;
          count_nxt        = CW'(count_r - 1'b1);
        end
        res_status_nxt = sst_pkg::ST_OK;
        res_slot_nxt   = idx_r;
      end
    end

    if (ctl.on_miss) begin
      res_slot_nxt = '0;
      if (cmd_r == sst_pkg::CMD_OPEN) begin
        if (free_avail) begin
          ram_we              = 1'b1;
          valid_nxt[free_sel] = 1'b1;
          count_nxt           = CW'(count_r + 1'b1);
          res_status_nxt      = sst_pkg::ST_OK;
          res_slot_nxt        = free_sel;
        end else begin
          res_status_nxt = sst_pkg::ST_FULL;
        end
      end else begin
        res_status_nxt = sst_pkg::ST_NOT_FOUND;
      end
    end

    if (ctl.load_out) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_slot_nxt   = slot_ext[2:0];
      out_count_nxt  = (count_ext > (CW + 4)'(15)) ? 4'hF : count_ext[3:0];
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      count_r      <= '0;
      idx_r        <= '0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      valid_r      <= valid_nxt;
      count_r      <= count_nxt;
      idx_r        <= idx_nxt;
      free_found_r <= free_found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    len_r        <= len_nxt;
    id_r         <= id_nxt;
    attr_r       <= attr_nxt;
    free_idx_r   <= free_idx_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_slot         = out_slot_r;
  assign out_active_count = out_count_r;

endmodule

[hdl/sst_ctrl.sv]
// slot table controller: sequences command capture, slot scan and result transfer
module sst_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sst_pkg::dp_stat_t  stat,
  output sst_pkg::ctrl_cmd_t ctl
);

  sst_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sst_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      sst_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.latch = 1'b1;
          state_nxt = sst_pkg::S_EVAL;
        end
      end
      sst_pkg::S_EVAL: begin
        if (stat.close_all || stat.too_short) begin
          ctl.early = 1'b1;
          state_nxt = sst_pkg::S_REPORT;
        end else begin
          ctl.scan_start = 1'b1;
          state_nxt      = sst_pkg::S_READ;
        end
      end
      // the ram registers the read data for the current index here, for the compare in S_CHECK
      sst_pkg::S_READ: begin
        state_nxt = sst_pkg::S_CHECK;
      end
      sst_pkg::S_CHECK: begin
        priority if (stat.hit) begin
          ctl.on_hit = 1'b1;
          state_nxt  = sst_pkg::S_REPORT;
        end else if (stat.last) begin
          ctl.on_miss = 1'b1;
          state_nxt   = sst_pkg::S_REPORT;
        end else begin
          ctl.step  = 1'b1;
          state_nxt = sst_pkg::S_READ;
        end
      end
      sst_pkg::S_REPORT: begin
        if (stat.out_free) begin
          ctl.load_out = 1'b1;
          state_nxt    = sst_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sst_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[bench/sst_checker.sv]
// checker for the stream slot table: predicts every result and compares it at the output
module sst_checker #(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_payload_len,
  input  logic [7:0]  in_stream_id,
  input  logic [7:0]  in_stream_type,
  input  logic [7:0]  in_device_id,
  input  logic [15:0] in_sample_rate,
  input  logic [7:0]  in_sample_format,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_status,
  input  logic [2:0]  out_slot,
  input  logic [3:0]  out_active_count,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    sst_pkg::status_t status;
    logic [2:0]       slot;
    logic [3:0]       count;
  } slot_result_t;

  logic        live  [SLOTS];
  logic [7:0]  ids   [SLOTS];
  logic [7:0]  kinds [SLOTS];
  logic [7:0]  devs  [SLOTS];
  logic [15:0] rates [SLOTS];
  logic [7:0]  fmts  [SLOTS];

  slot_result_t expected_q[$];
  slot_result_t res;
  slot_result_t want;

  // lowest live slot holding this id, or -1
  function automatic int lookup(logic [7:0] id);
    for (int i = 0; i < SLOTS; i++) begin
      if (live[i] && ids[i] == id) return i;
    end
    return -1;
  endfunction

  task automatic apply_cmd(input sst_pkg::cmd_t c, input logic [7:0] len,
                           input logic [7:0] id,
                           input logic [7:0] kind, input logic [7:0] dev,
                           input logic [15:0] rate, input logic [7:0] fmt,
                           output slot_result_t r);
    int hit;
    int idx;
    int n;
    logic [7:0] need;
    r.status = sst_pkg::ST_OK;
    idx = 0;
    case (c)
      sst_pkg::CMD_OPEN: begin
        if (len < sst_pkg::OPEN_MIN_LEN) begin
          r.status = sst_pkg::ST_SHORT;
        end else if (lookup(id) >= 0) begin
          r.status = sst_pkg::ST_IN_USE;
        end else begin
          r.status = sst_pkg::ST_FULL;
          for (int i = 0; i < SLOTS; i++) begin
            if (!live[i] && r.status == sst_pkg::ST_FULL) begin
              live[i]  = 1'b1;
              ids[i]   = id;
              kinds[i] = kind;
              devs[i]  = dev;
              rates[i] = rate;
              fmts[i]  = fmt;
              r.status = sst_pkg::ST_OK;
              idx      = i;
            end
          end
        end
      end
      sst_pkg::CMD_DATA, sst_pkg::CMD_CLOSE: begin
        need = (c == sst_pkg::CMD_DATA) ? sst_pkg::DATA_MIN_LEN : sst_pkg::CLOSE_MIN_LEN;
        if (len < need) begin
          r.status = sst_pkg::ST_SHORT;
        end else begin
          hit = lookup(id);
          if (hit < 0) begin
            r.status = sst_pkg::ST_NOT_FOUND;
          end else begin
            if (c == sst_pkg::CMD_CLOSE) live[hit] = 1'b0;
            idx = hit;
          end
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) live[i] = 1'b0;
      end
    endcase
    n = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (live[i]) n++;
    end
    if (n > 15) n = 15;
    r.slot  = idx[2:0];
    r.count = n[3:0];
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) live[i] = 1'b0;
      expected_q.delete();
      errors  = 0;
      pending = 0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_cmd(sst_pkg::cmd_t'(in_cmd), in_payload_len, in_stream_id, in_stream_type,
                  in_device_id, in_sample_rate, in_sample_format, res);
        expected_q.push_back(res);
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: result with no command waiting: status %0d slot %0d count %0d",
                   $time, out_status, out_slot, out_active_count);
        end else begin
          want = expected_q.pop_front();
          if (out_status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          end
          if (out_slot !== want.slot) begin
            errors++;
            $display("%0t: slot expected %0d actual %0d", $time, want.slot, out_slot);
          end
          if (out_active_count !== want.count) begin
            errors++;
            $display("%0t: active count expected %0d actual %0d",
                     $time, want.count, out_active_count);
          end
        end
      end
      pending = expected_q.size();
    end
  end

endmodule

[bench/tb_stream_slot_table.sv]
// testbench top for the stream slot table: clock, reset, command stimulus and verdict
module tb_stream_slot_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 8;
  localparam int LIMIT = 600000;

  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic [1:0]  in_cmd           = sst_pkg::CMD_CLOSE_ALL;
  logic [7:0]  in_payload_len   = 8'd0;
  logic [7:0]  in_stream_id     = 8'd0;
  logic [7:0]  in_stream_type   = 8'd0;
  logic [7:0]  in_device_id     = 8'd0;
  logic [15:0] in_sample_rate   = 16'd0;
  logic [7:0]  in_sample_format = 8'd0;
  logic        out_stall        = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [2:0]  out_slot;
  logic [3:0]  out_active_count;

  int err_count;
  int pend_count;
  int cycles    = 0;
  int hold_left = 0;
  logic calm    = 1'b0;

  always #1 clk = ~clk;

  stream_slot_table #(.SLOTS(SLOTS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .in_payload_len(in_payload_len), .in_stream_id(in_stream_id),
    .in_stream_type(in_stream_type), .in_device_id(in_device_id),
    .in_sample_rate(in_sample_rate), .in_sample_format(in_sample_format),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_slot(out_slot), .out_active_count(out_active_count)
  );

  sst_checker #(.SLOTS(SLOTS)) checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .in_payload_len(in_payload_len), .in_stream_id(in_stream_id),
    .in_stream_type(in_stream_type), .in_device_id(in_device_id),
    .in_sample_rate(in_sample_rate), .in_sample_format(in_sample_format),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_slot(out_slot), .out_active_count(out_active_count),
    .errors(err_count), .pending(pend_count)
  );

  // mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side back-pressure
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      hold_left <= pick_gap();
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_cmd(input sst_pkg::cmd_t c, input logic [7:0] len,
                          input logic [7:0] id,
                          input logic [7:0] kind, input logic [7:0] dev,
                          input logic [15:0] rate, input logic [7:0] fmt);
    in_cmd           <= c;
    in_payload_len   <= len;
    in_stream_id     <= id;
    in_stream_type   <= kind;
    in_device_id     <= dev;
    in_sample_rate   <= rate;
    in_sample_format <= fmt;
    in_valid         <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // command whose attribute bytes do not matter
  task automatic short_cmd(input sst_pkg::cmd_t c, input logic [7:0] len,
                           input logic [7:0] id);
    send_cmd(c, len, id, 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pend_count != 0) @(negedge clk);
  endtask

  task automatic random_cmd();
    int r;
    sst_pkg::cmd_t c;
    logic [7:0] len;
    logic [7:0] id;
    logic [7:0] floor_len;
    r = $urandom_range(0, 99);
    if (r < 36) c = sst_pkg::CMD_OPEN;
    else if (r < 63) c = sst_pkg::CMD_DATA;
    else if (r < 90) c = sst_pkg::CMD_CLOSE;
    else if (r < 93) c = sst_pkg::CMD_CLOSE_ALL;
    else c = sst_pkg::cmd_t'($urandom_range(0, 3));
    floor_len = (c == sst_pkg::CMD_OPEN) ? sst_pkg::OPEN_MIN_LEN :
                (c == sst_pkg::CMD_DATA) ? sst_pkg::DATA_MIN_LEN : sst_pkg::CLOSE_MIN_LEN;
    if (r >= 93) len = 8'($urandom_range(0, 9));  // noise, often too short
    else if (c == sst_pkg::CMD_CLOSE_ALL) len = 8'($urandom_range(0, 255));
    else if ($urandom_range(0, 9) == 0) len = floor_len;
    else len = 8'($urandom_range(floor_len, 255));
    // a small pool of ids keeps hits, duplicates and a full table frequent
    if ($urandom_range(0, 6) == 0) id = 8'($urandom_range(0, 255));
    else id = 8'($urandom_range(0, 11));
    send_cmd(c, len, id, 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
  endtask

  initial begin
    int gap;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    short_cmd(sst_pkg::CMD_DATA, 8'd2, 8'd5);    // lookups on an empty table
    short_cmd(sst_pkg::CMD_CLOSE, 8'd1, 8'd5);
    send_cmd(sst_pkg::CMD_OPEN, 8'd7, 8'd9, 8'hff, 8'hff, 16'hffff, 8'hff);
    send_cmd(sst_pkg::CMD_OPEN, 8'd8, 8'd0, 8'h00, 8'h00, 16'h0000, 8'h00);
    send_cmd(sst_pkg::CMD_OPEN, 8'd255, 8'd255, 8'hff, 8'hff, 16'hffff, 8'hff);
    send_cmd(sst_pkg::CMD_OPEN, 8'd8, 8'd0, 8'h5a, 8'ha5, 16'h1234, 8'h3c);
    short_cmd(sst_pkg::CMD_DATA, 8'd1, 8'd0);
    short_cmd(sst_pkg::CMD_DATA, 8'd2, 8'd0);
    short_cmd(sst_pkg::CMD_CLOSE, 8'd0, 8'd255);
    short_cmd(sst_pkg::CMD_CLOSE, 8'd1, 8'd255);
    // refill the freed slot first, then fill the table
    for (int i = 1; i < 8; i++) begin
      send_cmd(sst_pkg::CMD_OPEN, 8'd8 + 8'(i), 8'(i), 8'($urandom), 8'($urandom),
               16'($urandom), 8'($urandom));
    end
    send_cmd(sst_pkg::CMD_OPEN, 8'd8, 8'd8, 8'h01, 8'h02, 16'h0304, 8'h05);
    send_cmd(sst_pkg::CMD_OPEN, 8'd8, 8'd3, 8'h01, 8'h02, 16'h0304, 8'h05);
    send_cmd(sst_pkg::CMD_OPEN, 8'd0, 8'd200, 8'h01, 8'h02, 16'h0304, 8'h05);
    short_cmd(sst_pkg::CMD_CLOSE_ALL, 8'd0, 8'd0);
    short_cmd(sst_pkg::CMD_DATA, 8'd2, 8'd0);
    short_cmd(sst_pkg::CMD_CLOSE_ALL, 8'd255, 8'd77);
    drain_results();

    for (int blk = 0; blk < 11; blk++) begin
      calm <= (blk % 4 == 3);
      for (int k = 0; k < 100; k++) begin
        random_cmd();
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      // hold off the sender until every result is back
      drain_results();
    end

    repeat (40) @(negedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
hdl/sst_pkg.sv
hdl/sst_ram.sv
hdl/sst_datapath.sv
hdl/sst_ctrl.sv
hdl/stream_slot_table.sv
bench/sst_checker.sv
bench/tb_stream_slot_table.sv
